[hw/rtl/ghb_pkg.sv]
// Shared types and constants of the grid histogram binner.
package ghb_pkg;

  // Grid size and the widths that follow from it.
  localparam int K_BINS = 64;
  localparam int E_BINS = 64;
  localparam int KW     = $clog2(K_BINS);
  localparam int EW     = $clog2(E_BINS);
  localparam int BW     = (KW > EW) ? KW : EW;
  localparam int CW     = (BW > 1) ? $clog2(BW) : 1;
  localparam int NBINS  = K_BINS * E_BINS;
  localparam int AW     = $clog2(NBINS);

  // Field widths.
  localparam int VAL_W  = 32;
  localparam int STEP_W = 31;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;
  localparam int BIN_W  = 6;
  localparam int ENT_W  = CNT_W + SUM_W;
  localparam int DW     = STEP_W + BW + 1;
  localparam int IN_W   = 112;
  localparam int OUT_W  = 112;

  // Register reset values (Q15.16).
  localparam logic [VAL_W-1:0]  K_MIN_RST  = 32'hFFF6_0000;
  localparam logic [STEP_W-1:0] K_STEP_RST = 31'd20480;
  localparam logic [VAL_W-1:0]  E_MIN_RST  = 32'h0000_0000;
  localparam logic [STEP_W-1:0] E_STEP_RST = 31'd6144;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_K_MIN  = 2'd0,
    REG_K_STEP = 2'd1,
    REG_E_MIN  = 2'd2,
    REG_E_STEP = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIV,
    ST_ACCESS
  } state_e;

  // Request to a bin divider.
  typedef struct packed {
    logic              start;
    logic              below;
    logic [VAL_W-1:0]  x;
    logic [STEP_W-1:0] step;
  } div_req_t;

  // Status and result of a bin divider.
  typedef struct packed {
    logic          busy;
    logic          big;
    logic [BW-1:0] q;
  } div_res_t;

endpackage

[hw/rtl/ghb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ghb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ghb_bin_div.sv]
// Restoring divider that finds one bin index, one quotient bit per cycle.
// The quotient is only resolved up to BW bits; a larger quotient raises big.
module ghb_bin_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ghb_pkg::div_req_t  req_i,
  output ghb_pkg::div_res_t  res_o
);

  logic                         busy_q, busy_d;
  logic [ghb_pkg::CW-1:0]       cnt_q, cnt_d;
  logic [ghb_pkg::VAL_W-1:0]    rem_q, rem_d;
  logic [ghb_pkg::DW-1:0]       dv_q, dv_d;
  logic [ghb_pkg::BW-1:0]       quo_q, quo_d;
  logic                         big_q, big_d;
  logic [ghb_pkg::STEP_W-1:0]   step_eff;
  logic                         ge;

  // A zero step width acts as one.
  assign step_eff = (req_i.step == '0) ? ghb_pkg::STEP_W'(1) : req_i.step;
  assign ge = {(ghb_pkg::DW - ghb_pkg::VAL_W)'(0), rem_q} >= dv_q;

  // Start loads the divisor aligned to the top quotient bit; each step
  // tries one subtraction and shifts the divisor down.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    big_d  = big_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ghb_pkg::CW'(ghb_pkg::BW - 1);
      rem_d  = req_i.below ? '0 : req_i.x;
      dv_d   = ghb_pkg::DW'(step_eff) << (ghb_pkg::BW - 1);
      quo_d  = '0;
      big_d  = !req_i.below &&
               (ghb_pkg::DW'(req_i.x) >= (ghb_pkg::DW'(step_eff) << ghb_pkg::BW));
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - ghb_pkg::VAL_W'(dv_q);
      end
      quo_d = ghb_pkg::BW'({quo_q, ge});
      dv_d  = dv_q >> 1;
      cnt_d = cnt_q - ghb_pkg::CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    quo_q <= quo_d;
    big_q <= big_d;
  end

  assign res_o.busy = busy_q;
  assign res_o.big  = big_q;
  assign res_o.q    = quo_q;

endmodule

[hw/rtl/grid_histogram_binner.sv]
// Channel   Dir  Handshake         Payload
// config    in   cfg_we_i          cfg_addr_i (register index), cfg_wdata_i
// samples   in   s_tvalid/s_tready s_tdata (sample, read bins), s_tuser (command)
// results   out  m_tvalid/m_tready m_tdata (count, sum, dropped total), m_tuser
//
// Add starts the two bin dividers side by side, runs their BW steps, does one
// memory read and one write, and hands the result to the output register (an
// add outside the grid skips the memory). Read only reads; unused only replies.
// After reset and after a clear command the bin memory is swept to zero, one
// entry a cycle, over all NBINS (4096) entries; no sample is accepted meanwhile.
// A finished result waits in a holding register, so m_tready low stalls input
// only once a second result is ready.
module grid_histogram_binner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_addr_i,
  input  logic [31:0]                 cfg_wdata_i,
  // Sample requests.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // energy [31:0], momentum [63:32], intensity [95:64],
  // read_k_bin [101:96], read_e_bin [107:102], zero [111:108]
  input  logic [ghb_pkg::IN_W-1:0]    s_tdata,
  // cmd [1:0]
  input  logic [1:0]                  s_tuser,
  // Results.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // bin_count [31:0], bin_sum [79:32], out_of_range_count [111:80]
  output logic [ghb_pkg::OUT_W-1:0]   m_tdata,
  // sample_dropped [0]
  output logic [0:0]                  m_tuser
);

  // Configuration registers.
  logic [ghb_pkg::VAL_W-1:0]  k_min_q, e_min_q;
  logic [ghb_pkg::STEP_W-1:0] k_step_q, e_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_min_q  <= ghb_pkg::K_MIN_RST;
      k_step_q <= ghb_pkg::K_STEP_RST;
      e_min_q  <= ghb_pkg::E_MIN_RST;
      e_step_q <= ghb_pkg::E_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (ghb_pkg::reg_e'(cfg_addr_i))
        ghb_pkg::REG_K_MIN:  k_min_q  <= cfg_wdata_i;
        ghb_pkg::REG_K_STEP: k_step_q <= cfg_wdata_i[ghb_pkg::STEP_W-1:0];
        ghb_pkg::REG_E_MIN:  e_min_q  <= cfg_wdata_i;
        ghb_pkg::REG_E_STEP: e_step_q <= cfg_wdata_i[ghb_pkg::STEP_W-1:0];
      endcase
    end
  end

  // Input fields.
  ghb_pkg::cmd_e                 in_cmd;
  logic [ghb_pkg::VAL_W-1:0]     in_en, in_mo, in_it;
  logic [ghb_pkg::BIN_W-1:0]     in_rk, in_re;

  assign in_cmd = ghb_pkg::cmd_e'(s_tuser);
  assign in_en  = s_tdata[31:0];
  assign in_mo  = s_tdata[63:32];
  assign in_it  = s_tdata[95:64];
  assign in_rk  = s_tdata[101:96];
  assign in_re  = s_tdata[107:102];

  // Offsets from the lower grid edges, as 33-bit signed differences.
  logic [ghb_pkg::VAL_W:0] dk, de, dk_m1, de_m1;

  assign dk    = {in_mo[31], in_mo} - {k_min_q[31], k_min_q};
  assign de    = {in_en[31], in_en} - {e_min_q[31], e_min_q};
  assign dk_m1 = dk - 33'd1;
  assign de_m1 = de - 33'd1;

  // Bin dividers.
  ghb_pkg::div_req_t div_k_req, div_e_req;
  ghb_pkg::div_res_t div_k_res, div_e_res;
  logic              div_start;

  assign div_k_req.start = div_start;
  assign div_k_req.below = dk[ghb_pkg::VAL_W] || (dk == '0);
  assign div_k_req.x     = dk_m1[ghb_pkg::VAL_W-1:0];
  assign div_k_req.step  = k_step_q;
  assign div_e_req.start = div_start;
  assign div_e_req.below = de[ghb_pkg::VAL_W] || (de == '0);
  assign div_e_req.x     = de_m1[ghb_pkg::VAL_W-1:0];
  assign div_e_req.step  = e_step_q;

  ghb_bin_div u_div_k (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_k_req),
    .res_o  (div_k_res)
  );

  ghb_bin_div u_div_e (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_e_req),
    .res_o  (div_e_res)
  );

  // Bin memory: count in the low bits, sum above it.
  logic                       ram_we, ram_re;
  logic [ghb_pkg::AW-1:0]     ram_waddr, ram_raddr;
  logic [ghb_pkg::ENT_W-1:0]  ram_wdata, ram_rdata;

  ghb_ram #(
    .WIDTH (ghb_pkg::ENT_W),
    .DEPTH (ghb_pkg::NBINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control and datapath state.
  ghb_pkg::state_e             state_q, state_d;
  ghb_pkg::cmd_e               cmd_q, cmd_d;
  logic [ghb_pkg::AW-1:0]      clr_q, clr_d;
  logic [ghb_pkg::CNT_W-1:0]   dropped_q, dropped_d;
  logic                        pend_q, pend_d;
  logic                        m_valid_q, m_valid_d;
  logic [ghb_pkg::VAL_W-1:0]   it_q, it_d;
  logic [ghb_pkg::AW-1:0]      addr_q, addr_d;
  logic [ghb_pkg::CNT_W-1:0]   res_cnt_q, res_cnt_d;
  logic [ghb_pkg::SUM_W-1:0]   res_sum_q, res_sum_d;
  logic [ghb_pkg::CNT_W-1:0]   res_oor_q, res_oor_d;
  logic                        res_drop_q, res_drop_d;
  logic [ghb_pkg::CNT_W-1:0]   out_cnt_q, out_oor_q;
  logic [ghb_pkg::SUM_W-1:0]   out_sum_q;
  logic                        out_drop_q;
  logic                        out_load;

  // Bin lookup helpers.
  logic                        over;
  logic                        rd_in_range;
  logic [ghb_pkg::AW-1:0]      add_idx, rd_idx;
  logic [ghb_pkg::CNT_W-1:0]   old_cnt, new_cnt;
  logic [ghb_pkg::SUM_W-1:0]   old_sum, new_sum;
  logic [ghb_pkg::SUM_W:0]     sum_wide;
  logic [ghb_pkg::CNT_W-1:0]   dropped_inc;

  assign over = div_k_res.big || div_e_res.big ||
                (32'(div_k_res.q) >= 32'(ghb_pkg::K_BINS)) ||
                (32'(div_e_res.q) >= 32'(ghb_pkg::E_BINS));
  assign add_idx = ghb_pkg::AW'(div_k_res.q) * ghb_pkg::AW'(ghb_pkg::E_BINS) +
                   ghb_pkg::AW'(div_e_res.q);
  assign rd_in_range = (32'(in_rk) < 32'(ghb_pkg::K_BINS)) &&
                       (32'(in_re) < 32'(ghb_pkg::E_BINS));
  assign rd_idx = ghb_pkg::AW'(in_rk) * ghb_pkg::AW'(ghb_pkg::E_BINS) +
                  ghb_pkg::AW'(in_re);

  // Saturating bin update.
  assign old_cnt  = ram_rdata[ghb_pkg::CNT_W-1:0];
  assign old_sum  = ram_rdata[ghb_pkg::ENT_W-1:ghb_pkg::CNT_W];
  assign new_cnt  = (old_cnt == '1) ? old_cnt : old_cnt + ghb_pkg::CNT_W'(1);
  assign sum_wide = {old_sum[ghb_pkg::SUM_W-1], old_sum} +
                    {{(ghb_pkg::SUM_W + 1 - ghb_pkg::VAL_W){it_q[ghb_pkg::VAL_W-1]}}, it_q};
  always_comb begin
    if (sum_wide[ghb_pkg::SUM_W] != sum_wide[ghb_pkg::SUM_W-1]) begin
      new_sum = sum_wide[ghb_pkg::SUM_W] ? {1'b1, {(ghb_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(ghb_pkg::SUM_W-1){1'b1}}};
    end else begin
      new_sum = sum_wide[ghb_pkg::SUM_W-1:0];
    end
  end

  assign dropped_inc = (dropped_q == '1) ? dropped_q : dropped_q + ghb_pkg::CNT_W'(1);

  // A waiting result moves to the output register once it is free.
  assign out_load = pend_q && (!m_valid_q || m_tready);
  assign s_tready = (state_q == ghb_pkg::ST_IDLE) && !pend_q;

  // Next state and memory control.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    clr_d      = clr_q;
    dropped_d  = dropped_q;
    pend_d     = out_load ? 1'b0 : pend_q;
    it_d       = it_q;
    addr_d     = addr_q;
    res_cnt_d  = res_cnt_q;
    res_sum_d  = res_sum_q;
    res_oor_d  = res_oor_q;
    res_drop_d = res_drop_q;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_q;
    ram_wdata  = {new_sum, new_cnt};
    ram_re     = 1'b0;
    ram_raddr  = rd_idx;
    unique case (state_q)
      ghb_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ghb_pkg::AW'(1);
        if (clr_q == ghb_pkg::AW'(ghb_pkg::NBINS - 1)) begin
          state_d = ghb_pkg::ST_IDLE;
        end
      end
      ghb_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd_d      = in_cmd;
          it_d       = in_it;
          res_cnt_d  = '0;
          res_sum_d  = '0;
          res_oor_d  = dropped_q;
          res_drop_d = 1'b0;
          unique case (in_cmd)
            ghb_pkg::CMD_CLEAR: begin
              dropped_d = '0;
              res_oor_d = '0;
              pend_d    = 1'b1;
              clr_d     = '0;
              state_d   = ghb_pkg::ST_SWEEP;
            end
            ghb_pkg::CMD_ADD: begin
              div_start = 1'b1;
              state_d   = ghb_pkg::ST_DIV;
            end
            ghb_pkg::CMD_READ: begin
              if (rd_in_range) begin
                ram_re  = 1'b1;
                addr_d  = rd_idx;
                state_d = ghb_pkg::ST_ACCESS;
              end else begin
                pend_d = 1'b1;
              end
            end
            ghb_pkg::CMD_NONE: begin
              pend_d = 1'b1;
            end
          endcase
        end
      end
      ghb_pkg::ST_DIV: begin
        if (!div_k_res.busy && !div_e_res.busy) begin
          if (over) begin
            dropped_d  = dropped_inc;
            res_oor_d  = dropped_inc;
            res_drop_d = 1'b1;
            pend_d     = 1'b1;
            state_d    = ghb_pkg::ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = add_idx;
            addr_d    = add_idx;
            state_d   = ghb_pkg::ST_ACCESS;
          end
        end
      end
      ghb_pkg::ST_ACCESS: begin
        // Read data of the addressed bin is valid in this cycle.
        if (cmd_q == ghb_pkg::CMD_ADD) begin
          ram_we    = 1'b1;
          res_cnt_d = new_cnt;
          res_sum_d = new_sum;
        end else begin
          res_cnt_d = old_cnt;
          res_sum_d = old_sum;
        end
        pend_d  = 1'b1;
        state_d = ghb_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // Control state; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ghb_pkg::ST_SWEEP;
      cmd_q     <= ghb_pkg::CMD_NONE;
      clr_q     <= '0;
      dropped_q <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      clr_q     <= clr_d;
      dropped_q <= dropped_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    it_q       <= it_d;
    addr_q     <= addr_d;
    res_cnt_q  <= res_cnt_d;
    res_sum_q  <= res_sum_d;
    res_oor_q  <= res_oor_d;
    res_drop_q <= res_drop_d;
    if (out_load) begin
      out_cnt_q  <= res_cnt_q;
      out_sum_q  <= res_sum_q;
      out_oor_q  <= res_oor_q;
      out_drop_q <= res_drop_q;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {out_oor_q, out_sum_q, out_cnt_q};
  assign m_tuser  = out_drop_q;

  // The memory is written outside the sweep only by the add update.
  a_write_only_on_add: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != ghb_pkg::ST_SWEEP) |->
      (state_q == ghb_pkg::ST_ACCESS && cmd_q == ghb_pkg::CMD_ADD))
    else $error("bin memory written outside an add update");

  // The dropped total only steps up by one or clears.
  a_dropped_step: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !$stable(dropped_q) |->
      (dropped_q == '0 || dropped_q == $past(dropped_q) + ghb_pkg::CNT_W'(1)))
    else $error("dropped total changed by more than one");

  // A dropped sample reports an empty bin.
  a_dropped_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[79:0] == '0))
    else $error("dropped sample reports nonzero bin fields");

  // No sample is taken while the memory is being cleared.
  a_no_accept_in_sweep: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == ghb_pkg::ST_SWEEP) |-> !s_tready)
    else $error("sample accepted during clearing sweep");

endmodule
